/* design/triangle_plane_equation_assert.svh */
// Assertion macros shared by the checker of triangle_plane_equation.
`ifndef TRIANGLE_PLANE_EQUATION_ASSERT_SVH
`define TRIANGLE_PLANE_EQUATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define TPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tpe_pkg.sv */
// Types and constants of the triangle plane equation unit.
`timescale 1ns / 1ps
package tpe_pkg;

  localparam int FIELD_WIDTH  = 32;
  localparam int NORMAL_WIDTH = 32;
  localparam int OFFSET_WIDTH = 40;
  localparam int CFG_WIDTH    = 32;

  localparam logic [CFG_WIDTH-1:0] MIN_MAG_RESET = 32'd4295;

  // Offset rounding: add half, then drop 30 fraction bits.
  localparam int OFFSET_SHIFT = 30;
  localparam int ROUND_HALF   = 536870912;

  localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_MIN = 40'sh80_0000_0000;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] ax;
    logic signed [FIELD_WIDTH-1:0] ay;
    logic signed [FIELD_WIDTH-1:0] az;
    logic signed [FIELD_WIDTH-1:0] bx;
    logic signed [FIELD_WIDTH-1:0] by;
    logic signed [FIELD_WIDTH-1:0] bz;
    logic signed [FIELD_WIDTH-1:0] cx;
    logic signed [FIELD_WIDTH-1:0] cy;
    logic signed [FIELD_WIDTH-1:0] cz;
  } tpe_in_t;

  typedef struct packed {
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic signed [OFFSET_WIDTH-1:0] plane_offset;
    logic                           degenerate;
  } tpe_out_t;

endpackage

/* design/triangle_plane_equation.sv */
// Top level of the triangle plane equation unit: plane with unit normal from three points.
`timescale 1ns / 1ps
// Takes one triangle (three Q16.16 vertices) per cycle while in_ready is high and returns
// its unit normal in Q1.30, the plane offset D = -(n . A) in Q24.16 (saturated to 40
// bits) and a degenerate flag set when the cross product length is zero or below
// cfg_wdata's stored threshold. A new triangle is accepted every cycle unless a result
// waits in the skid stage. The square root settles one root bit per stage, and 32
// restoring divide stages form the normal. An output register with a skid stage keeps
// input and output apart.
module triangle_plane_equation #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tpe_pkg::tpe_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tpe_pkg::tpe_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [tpe_pkg::CFG_WIDTH-1:0]    cfg_wdata
);
  import tpe_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int VW  = W + 1;          // edge vector
  localparam int PW2 = 2 * W + 2;      // edge product
  localparam int CW  = 2 * W + 2;      // cross product, signed
  localparam int CM  = 2 * W + 1;      // cross product magnitude
  localparam int LO  = W + 1;          // low split of magnitude
  localparam int HI  = CM - LO;
  localparam int SW  = 4 * W + 4;      // squared length
  localparam int N   = 2 * W + 34;     // root bits
  localparam int RW  = N + 2;          // root remainder
  localparam int NW  = 2 * W + 65;     // normal dividend
  localparam int DW  = N + 2;          // divide remainder
  localparam int QW  = NORMAL_WIDTH;
  localparam int PW  = QW + W;         // normal times coordinate
  localparam int DTW = PW + 2;         // dot product
  localparam int TW  = DTW + 1 - OFFSET_SHIFT;
  localparam int EW  = (TW > OFFSET_WIDTH + 1) ? TW : OFFSET_WIDTH + 1;

  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // configuration
  logic [CFG_WIDTH-1:0]   min_mag_r;
  logic [2*CFG_WIDTH-1:0] m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r <= MIN_MAG_RESET;
    end else if (cfg_we) begin
      min_mag_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    m2_r <= min_mag_r * min_mag_r;
  end

  // stage 1: edge vectors
  logic signed [W-1:0] crd [9];
  always_comb begin
    crd[0] = W'(in_data.ax);
    crd[1] = W'(in_data.ay);
    crd[2] = W'(in_data.az);
    crd[3] = W'(in_data.bx);
    crd[4] = W'(in_data.by);
    crd[5] = W'(in_data.bz);
    crd[6] = W'(in_data.cx);
    crd[7] = W'(in_data.cy);
    crd[8] = W'(in_data.cz);
  end

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic signed [VW-1:0] s1_vv_r [3];
  logic signed [VW-1:0] s1_ww_r [3];
  logic [2:0][W-1:0]    s1_a_r, s2_a_r, s3_a_r, s4_a_r;
  logic signed [PW2-1:0] s2_t_r [3];
  logic signed [PW2-1:0] s2_u_r [3];
  logic [2:0][CM-1:0]   s3_mag_r, s4_mag_r;
  logic [2:0]           s3_sgn_r, s4_sgn_r;
  logic [2*HI-1:0]      s4_hh_r [3];
  logic [HI+LO-1:0]     s4_hl_r [3];
  logic [2*LO-1:0]      s4_ll_r [3];

  logic signed [CW-1:0] c_nxt [3];
  logic [SW-1:0]        s_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = CW'(s2_t_r[i]) - CW'(s2_u_r[i]);
    end
    s_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s_nxt = s_nxt + (SW'(s4_hh_r[i]) << (2 * LO)) + (SW'(s4_hl_r[i]) << (LO + 1))
            + SW'(s4_ll_r[i]);
    end
  end

  // square root pipeline, index 0 is loaded with the squared length
  logic               sq_v_r   [0:N];
  logic [SW-1:0]      sq_sh_r  [0:N];
  logic [RW-1:0]      sq_rem_r [0:N];
  logic [N-1:0]       sq_root_r[0:N];
  logic [2:0][W-1:0]  sq_a_r   [0:N];
  logic [2:0][CM-1:0] sq_mag_r [0:N];
  logic [2:0]         sq_sgn_r [0:N];
  logic               sq_deg_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      s1_v_r   <= in_valid;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      s4_v_r   <= s3_v_r;
      sq_v_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_vv_r[i] <= VW'(crd[3+i]) - VW'(crd[6+i]);
        s1_ww_r[i] <= VW'(crd[i]) - VW'(crd[3+i]);
        s1_a_r[i]  <= crd[i];
      end
      s2_t_r[0] <= s1_vv_r[1] * s1_ww_r[2];
      s2_u_r[0] <= s1_vv_r[2] * s1_ww_r[1];
      s2_t_r[1] <= s1_vv_r[2] * s1_ww_r[0];
      s2_u_r[1] <= s1_vv_r[0] * s1_ww_r[2];
      s2_t_r[2] <= s1_vv_r[0] * s1_ww_r[1];
      s2_u_r[2] <= s1_vv_r[1] * s1_ww_r[0];
      s2_a_r    <= s1_a_r;
      for (int i = 0; i < 3; i++) begin
        s3_sgn_r[i] <= c_nxt[i][CW-1];
        s3_mag_r[i] <= c_nxt[i][CW-1] ? CM'(-c_nxt[i]) : CM'(c_nxt[i]);
      end
      s3_a_r <= s2_a_r;
      for (int i = 0; i < 3; i++) begin
        s4_hh_r[i] <= s3_mag_r[i][CM-1:LO] * s3_mag_r[i][CM-1:LO];
        s4_hl_r[i] <= s3_mag_r[i][CM-1:LO] * s3_mag_r[i][LO-1:0];
        s4_ll_r[i] <= s3_mag_r[i][LO-1:0] * s3_mag_r[i][LO-1:0];
      end
      s4_a_r   <= s3_a_r;
      s4_mag_r <= s3_mag_r;
      s4_sgn_r <= s3_sgn_r;
      sq_sh_r[0]   <= s_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_a_r[0]    <= s4_a_r;
      sq_mag_r[0]  <= s4_mag_r;
      sq_sgn_r[0]  <= s4_sgn_r;
      // a zero cross product is degenerate even with a zero threshold
      sq_deg_r[0]  <= (s_nxt == '0) || (s_nxt < SW'(m2_r));
    end
  end

  for (genvar g = 1; g <= N; g++) begin : g_sqrt
    logic [RW+1:0] remx;
    logic [RW+1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [N-1:0]  root_nxt;

    always_comb begin
      remx     = {sq_rem_r[g-1], sq_sh_r[g-1][SW-1 -: 2]};
      trial    = (RW + 2)'({sq_root_r[g-1], 2'b01});
      ge       = (remx >= trial);
      rem_nxt  = ge ? RW'(remx - trial) : RW'(remx);
      root_nxt = {sq_root_r[g-1][N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[g] <= 1'b0;
      end else if (en) begin
        sq_v_r[g] <= sq_v_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sh_r[g]   <= sq_sh_r[g-1] << 2;
        sq_rem_r[g]  <= rem_nxt;
        sq_root_r[g] <= root_nxt;
        sq_a_r[g]    <= sq_a_r[g-1];
        sq_mag_r[g]  <= sq_mag_r[g-1];
        sq_sgn_r[g]  <= sq_sgn_r[g-1];
        sq_deg_r[g]  <= sq_deg_r[g-1];
      end
    end
  end

  // normal divide pipeline: (|c_i| * 2^63 + r) / (2r), 32 quotient bits
  logic               dv_v_r   [0:QW];
  logic [N:0]         dv_den_r [0:QW];
  logic [2:0][DW-1:0] dv_rem_r [0:QW];
  logic [2:0][QW-1:0] dv_lo_r  [0:QW];
  logic [2:0][QW-1:0] dv_q_r   [0:QW];
  logic [2:0][W-1:0]  dv_a_r   [0:QW];
  logic [2:0]         dv_sgn_r [0:QW];
  logic               dv_deg_r [0:QW];

  logic [NW-1:0] num_nxt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = (NW'(sq_mag_r[N][i]) << 63) + NW'(sq_root_r[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_den_r[0] <= {sq_root_r[N], 1'b0};
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= DW'(num_nxt[i] >> QW);
        dv_lo_r[0][i]  <= num_nxt[i][QW-1:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_a_r[0]   <= sq_a_r[N];
      dv_sgn_r[0] <= sq_sgn_r[N];
      dv_deg_r[0] <= sq_deg_r[N];
    end
  end

  for (genvar g = 1; g <= QW; g++) begin : g_div
    logic [2:0][DW-1:0] remx;
    logic [2:0]         ge;
    logic [2:0][DW-1:0] rem_nxt;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        remx[i]    = {dv_rem_r[g-1][i][DW-2:0], dv_lo_r[g-1][i][QW-1]};
        ge[i]      = (remx[i] >= DW'(dv_den_r[g-1]));
        rem_nxt[i] = ge[i] ? remx[i] - DW'(dv_den_r[g-1]) : remx[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[g] <= 1'b0;
      end else if (en) begin
        dv_v_r[g] <= dv_v_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den_r[g] <= dv_den_r[g-1];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[g][i] <= rem_nxt[i];
          dv_lo_r[g][i]  <= dv_lo_r[g-1][i] << 1;
          dv_q_r[g][i]   <= {dv_q_r[g-1][i][QW-2:0], ge[i]};
        end
        dv_a_r[g]   <= dv_a_r[g-1];
        dv_sgn_r[g] <= dv_sgn_r[g-1];
        dv_deg_r[g] <= dv_deg_r[g-1];
      end
    end
  end

  // signed normal, products with A, dot product
  logic                 nm_v_r, pr_v_r, dt_v_r;
  logic signed [QW-1:0] nm_n_r [3];
  logic [2:0][W-1:0]    nm_a_r;
  logic                 nm_deg_r, pr_deg_r, dt_deg_r;
  logic signed [PW-1:0] pr_p_r [3];
  logic signed [QW-1:0] pr_n_r [3];
  logic signed [QW-1:0] dt_n_r [3];
  logic signed [DTW-1:0] dt_dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
      pr_v_r <= 1'b0;
      dt_v_r <= 1'b0;
    end else if (en) begin
      nm_v_r <= dv_v_r[QW];
      pr_v_r <= nm_v_r;
      dt_v_r <= pr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nm_n_r[i] <= dv_sgn_r[QW][i] ? -dv_q_r[QW][i] : dv_q_r[QW][i];
        pr_p_r[i] <= PW'(nm_n_r[i]) * PW'($signed(nm_a_r[i]));
        pr_n_r[i] <= nm_n_r[i];
        dt_n_r[i] <= pr_n_r[i];
      end
      nm_a_r   <= dv_a_r[QW];
      nm_deg_r <= dv_deg_r[QW];
      pr_deg_r <= nm_deg_r;
      dt_dot_r <= DTW'(pr_p_r[0]) + DTW'(pr_p_r[1]) + DTW'(pr_p_r[2]);
      dt_deg_r <= pr_deg_r;
    end
  end

  // round, saturate and zero degenerate results
  logic signed [DTW:0]           neg_dot;
  logic signed [TW-1:0]          off_sh;
  logic signed [EW-1:0]          off_ext;
  logic signed [OFFSET_WIDTH-1:0] off_sat;
  tpe_out_t                      res_nxt;

  always_comb begin
    neg_dot = -((DTW + 1)'(dt_dot_r)) + (DTW + 1)'(ROUND_HALF);
    off_sh  = TW'(neg_dot >>> OFFSET_SHIFT);
    off_ext = EW'(off_sh);
    if (off_ext > EW'(OFFSET_MAX)) begin
      off_sat = OFFSET_MAX;
    end else if (off_ext < EW'(OFFSET_MIN)) begin
      off_sat = OFFSET_MIN;
    end else begin
      off_sat = OFFSET_WIDTH'(off_ext);
    end
    if (dt_deg_r) begin
      res_nxt = '0;
      res_nxt.degenerate = 1'b1;
    end else begin
      res_nxt.normal_x     = dt_n_r[0];
      res_nxt.normal_y     = dt_n_r[1];
      res_nxt.normal_z     = dt_n_r[2];
      res_nxt.plane_offset = off_sat;
      res_nxt.degenerate   = 1'b0;
    end
  end

  // output register with skid stage
  logic     out_v_r;
  tpe_out_t out_r, skid_r;
  logic     push, take;

  assign push = en && dt_v_r;
  assign take = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* design/tpe_checker.sv */
// Port checker for triangle_plane_equation and its bind.
`timescale 1ns / 1ps
`include "triangle_plane_equation_assert.svh"
module tpe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tpe_pkg::tpe_out_t out_data
);
  import tpe_pkg::*;

  // hold a stalled result
  `TPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // input stalls only behind a waiting result
  `TPE_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid, "input stalled with empty output")

  `TPE_ASSERT_NOW(a_degen_zero, clk, rst_n, out_valid && out_data.degenerate, out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0 && out_data.plane_offset == '0, "degenerate item not zeroed")

  `TPE_ASSERT_NOW(a_normal_nonzero, clk, rst_n, out_valid && !out_data.degenerate, out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0, "zero normal on valid triangle")

endmodule

bind triangle_plane_equation tpe_checker u_tpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/sv/plane_checker.sv */
// Checker for triangle_plane_equation: predicts each triangle's plane and compares results.
`timescale 1ns / 1ps
module plane_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  tpe_pkg::tpe_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  tpe_pkg::tpe_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [tpe_pkg::CFG_WIDTH-1:0] cfg_wdata,
  output int                            mismatches,
  output int                            planes_waiting,
  output int                            planes_checked,
  output int                            flat_seen
);
  import tpe_pkg::*;

  logic [CFG_WIDTH-1:0] min_mag;
  tpe_out_t             planes_due[$];

  // Integer square root, one result bit per pass.
  function automatic logic [255:0] root_of(logic [255:0] a);
    logic [255:0] num, res, bitv;
    num  = a;
    res  = '0;
    bitv = 256'b1 << 254;
    while (bitv != 0 && bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic tpe_out_t plane_of(tpe_in_t t, logic [CFG_WIDTH-1:0] thr);
    logic signed [127:0] p[9];
    logic signed [127:0] v[3];
    logic signed [127:0] w[3];
    logic signed [127:0] c[3];
    logic signed [127:0] dot, d, nq;
    logic [127:0]        mag[3];
    logic [255:0]        s, m2, r, q;
    tpe_out_t            o;
    int                  j, k;
    p[0] = t.ax; p[1] = t.ay; p[2] = t.az;
    p[3] = t.bx; p[4] = t.by; p[5] = t.bz;
    p[6] = t.cx; p[7] = t.cy; p[8] = t.cz;
    for (int i = 0; i < 3; i++) begin
      v[i] = p[3+i] - p[6+i];
      w[i] = p[i] - p[3+i];
    end
    s = '0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      c[i] = v[j] * w[k] - v[k] * w[j];
      mag[i] = c[i][127] ? -c[i] : c[i];
      s = s + {128'b0, mag[i]} * {128'b0, mag[i]};
    end
    m2 = {224'b0, thr} * {224'b0, thr};
    o = '0;
    if (s == 0 || s < m2) begin
      o.degenerate = 1'b1;
      return o;
    end
    r = root_of(s << 64);
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      // Round half away from zero on the magnitude, then restore the sign.
      q  = (({128'b0, mag[i]} << 63) + r) / (r << 1);
      nq = q[127:0];
      if (c[i][127]) nq = -nq;
      case (i)
        0: o.normal_x = nq[31:0];
        1: o.normal_y = nq[31:0];
        default: o.normal_z = nq[31:0];
      endcase
      dot = dot + nq * p[i];
    end
    d = (-dot + (128'sd1 <<< 29)) >>> OFFSET_SHIFT;
    if (d > 128'sh7F_FFFF_FFFF) o.plane_offset = OFFSET_MAX;
    else if (d < -128'sh80_0000_0000) o.plane_offset = OFFSET_MIN;
    else o.plane_offset = d[OFFSET_WIDTH-1:0];
    return o;
  endfunction

  function automatic bit same_plane(tpe_out_t a, tpe_out_t b);
    return a.normal_x == b.normal_x && a.normal_y == b.normal_y &&
           a.normal_z == b.normal_z && a.plane_offset == b.plane_offset &&
           a.degenerate == b.degenerate;
  endfunction

  assign planes_waiting = planes_due.size();

  always @(posedge clk) begin
    tpe_out_t want;
    if (!rst_n) begin
      min_mag        = MIN_MAG_RESET;
      mismatches     = 0;
      planes_checked = 0;
      flat_seen      = 0;
      planes_due.delete();
    end else begin
      if (cfg_we) min_mag = cfg_wdata;
      if (in_valid && in_ready) planes_due = {planes_due, plane_of(in_data, min_mag)};
      if (out_valid && out_ready) begin
        if (planes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = planes_due.pop_front();
          planes_checked++;
          if (out_data.degenerate) flat_seen++;
          if (!same_plane(want, out_data)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch nx %h/%h ny %h/%h nz %h/%h d %h/%h flat %b/%b (exp/act)",
                       want.normal_x, out_data.normal_x, want.normal_y, out_data.normal_y,
                       want.normal_z, out_data.normal_z, want.plane_offset,
                       out_data.plane_offset, want.degenerate, out_data.degenerate);
          end
        end
      end
    end
  end
endmodule

/* tb/sv/testbench.sv */
// Top of the triangle_plane_equation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import tpe_pkg::*;

  localparam int LATENCY = 2 * 32 + 76;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tpe_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tpe_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  int                   mismatches, planes_waiting, planes_checked, flat_seen;
  int                   sent = 0;
  bit                   calm = 1'b0;
  bit                   long_hold_done = 1'b0;

  always #6 clk = ~clk;

  triangle_plane_equation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  plane_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .planes_waiting(planes_waiting),
    .planes_checked(planes_checked), .flat_seen(flat_seen)
  );

  function automatic tpe_in_t tri_of(int a0, int a1, int a2, int b0, int b1, int b2,
                                     int c0, int c1, int c2);
    tpe_in_t t;
    t.ax = a0; t.ay = a1; t.az = a2;
    t.bx = b0; t.by = b1; t.bz = b2;
    t.cx = c0; t.cy = c1; t.cz = c2;
    return t;
  endfunction

  function automatic int near(int base, int spread);
    return base + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic tpe_in_t random_tri();
    int a[3], d[3], k, b;
    case ($urandom_range(0, 9))
      0, 1, 2: return tri_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
      3, 4: begin
        // tiny triangle around a random point: lands near the threshold
        for (int i = 0; i < 3; i++) a[i] = $urandom;
        b = $urandom_range(1, 80);
        return tri_of(a[0], a[1], a[2], near(a[0], b), near(a[1], b), near(a[2], b),
                      near(a[0], b), near(a[1], b), near(a[2], b));
      end
      5, 6: begin
        // collinear points, sometimes nudged off the line
        for (int i = 0; i < 3; i++) begin
          a[i] = near(0, 1 << 28);
          d[i] = near(0, 1 << $urandom_range(0, 20));
        end
        k = $urandom_range(1, 5);
        b = $urandom_range(0, 1);
        return tri_of(a[0], a[1], a[2], a[0] + d[0], a[1] + d[1], a[2] + d[2],
                      a[0] + k * d[0] + b, a[1] + k * d[1], a[2] + k * d[2]);
      end
      default: begin
        b = 1 << $urandom_range(4, 24);
        return tri_of(near(0, b), near(0, b), near(0, b), near(0, b), near(0, b),
                      near(0, b), near(0, b), near(0, b), near(0, b));
      end
    endcase
  endfunction

  task automatic send(tpe_in_t t);
    bit took;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (planes_waiting != 0) @(negedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic set_threshold(logic [CFG_WIDTH-1:0] thr);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic directed();
    int mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(tri_of(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send(tri_of(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send(tri_of(mx, 0, 0, mn, 0, 0, 0, mx, 0));
    send(tri_of(mx, mn, mx, mn, mx, mn, mx, mx, mn));
    send(tri_of(mn, mx, mn, mx, mn, mx, mn, mn, mx));
    send(tri_of(0, 0, 0, 1 << 16, 0, 0, 0, 1 << 16, 0));
    send(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send(tri_of(0, 0, 0, 65, 0, 0, 0, 66, 0));
    send(tri_of(0, 0, 0, 66, 0, 0, 0, 66, 0));
    send(tri_of(5, 5, 5, 10, 10, 10, 15, 15, 15));
    send(tri_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 0, 32'h0000_FFFF));
    send(tri_of(mx, mx, mx, mx - 1, mx, mx, mx, mx - 1, mx));
    send(tri_of(mn, mn, mn, mn + 1, mn, mn, mn, mn, mn + 1));
    send(tri_of(-1, -1, -1, 1, 1, 1, 1, -1, 0));
    send(tri_of(1 << 30, 1 << 30, 1 << 30, 1 << 30, -(1 << 30), 0, -(1 << 30), 0, 0));
  endtask

  // receiver: random stalls, one long hold-off once the pipe is busy
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && sent > 300) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    #(12 * 2_000_000);
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [CFG_WIDTH-1:0] thr_list[6];
    int                   count_list[6];
    thr_list   = '{MIN_MAG_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd4356, 32'd0};
    count_list = '{0, 200, 100, 200, 200, 300};
    thr_list[5] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain();
    for (int ph = 1; ph < 6; ph++) begin
      set_threshold(thr_list[ph]);
      if (ph == 1) directed();
      for (int i = 0; i < count_list[ph]; i++) begin
        if (ph == 5 && i > count_list[ph] / 2) calm = 1'b1;
        send(random_tri());
      end
      drain();
    end
    $display("checked %0d planes (%0d degenerate) across 6 threshold settings",
             planes_checked, flat_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
